// ===== design/gamepad_input_conditioner_core_macros.svh =====
// assertion macros for the gamepad input conditioner checker
// no dependencies; included by the checker file
`ifndef GAMEPAD_INPUT_CONDITIONER_CORE_MACROS_SVH
`define GAMEPAD_INPUT_CONDITIONER_CORE_MACROS_SVH

// clocked assertion, masked while reset is held
`define GIC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds across reset
`define GIC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/gic_pkg.sv =====
// shared constants and types for the gamepad input conditioner
// no dependencies; used by the core, the root/divide unit and the checker
package gic_pkg;

  localparam int IDLE_COUNT_BITS = 24;
  localparam logic [IDLE_COUNT_BITS-1:0] IDLE_MAX = {IDLE_COUNT_BITS{1'b1}};

  localparam logic [14:0] FULL_SCALE  = 15'd32767;
  localparam logic [7:0]  TRIG_FULL   = 8'd255;
  localparam logic [15:0] MASK_START  = 16'h0010;
  localparam logic [15:0] MASK_A      = 16'h1000;
  localparam logic [15:0] COARSE_AXIS = 16'hC000;

  localparam logic [14:0] STICK_DZ_RST  = 15'd7864;
  localparam logic [7:0]  TRIG_DZ_RST   = 8'd30;
  localparam logic [14:0] DIR_THR_RST   = 15'd9830;

  // operand widths of the shared root/divide unit
  localparam int DIVIDEND_W = 46;
  localparam int DIVISOR_W  = 31;
  localparam int RADICAND_W = 32;
  localparam int QUOT_W     = 16;

  typedef enum logic [1:0] {
    CFG_PAD_DISABLED = 2'd0,
    CFG_STICK_DZ     = 2'd1,
    CFG_TRIG_DZ      = 2'd2,
    CFG_DIR_THR      = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    UOP_DIV  = 2'b01,
    UOP_SQRT = 2'b10
  } unit_op_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [QUOT_W-1:0] result;
  } unit_rsp_t;

endpackage

// ===== design/gic_root_div.sv =====
// shared iterative unit: restoring divide or digit-by-digit square root
// one quotient/root bit per cycle; depends on gic_pkg
module gic_root_div import gic_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  unit_req_t             req,
  input  logic [DIVIDEND_W-1:0] operand_a,
  input  logic [DIVISOR_W-1:0]  operand_b,
  output unit_rsp_t             rsp
);

  logic                  busy_r;
  logic                  done_r;
  unit_op_t              op_r;
  logic [3:0]            cnt_r;
  logic [DIVIDEND_W-1:0] rem_r;
  logic [DIVIDEND_W-1:0] dsh_r;
  logic [QUOT_W-1:0]     q_r;

  logic [19:0]           rem2;
  logic [DIVIDEND_W-1:0] sub_a;
  logic [DIVIDEND_W-1:0] sub_b;
  logic [DIVIDEND_W:0]   diff;
  logic                  fits;

  // one subtractor serves both operations
  always_comb begin
    rem2 = {rem_r[17:0], dsh_r[RADICAND_W-1 -: 2]};
    if (op_r == UOP_DIV) begin
      sub_a = rem_r;
      sub_b = dsh_r;
    end else begin
      sub_a = DIVIDEND_W'(rem2);
      sub_b = DIVIDEND_W'({q_r, 2'b01});
    end
    diff = {1'b0, sub_a} - {1'b0, sub_b};
    fits = !diff[DIVIDEND_W];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= 4'd15;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 4'd1;
        if (cnt_r == 4'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      op_r <= req.op;
      q_r  <= '0;
      if (req.op == UOP_DIV) begin
        rem_r <= operand_a;
        dsh_r <= {operand_b, 15'd0};
      end else begin
        rem_r <= '0;
        dsh_r <= DIVIDEND_W'(operand_a[RADICAND_W-1:0]);
      end
    end else if (busy_r) begin
      q_r <= {q_r[QUOT_W-2:0], fits};
      if (op_r == UOP_DIV) begin
        if (fits) rem_r <= diff[DIVIDEND_W-1:0];
        dsh_r <= dsh_r >> 1;
      end else begin
        rem_r <= fits ? diff[DIVIDEND_W-1:0] : DIVIDEND_W'(rem2);
        dsh_r <= DIVIDEND_W'({dsh_r[RADICAND_W-3:0], 2'b00});
      end
    end
  end

  assign rsp.busy   = busy_r;
  assign rsp.done   = done_r;
  assign rsp.result = q_r;

endmodule

// ===== design/gamepad_input_conditioner_core.sv =====
// gamepad input conditioner top level: handshakes, edge detect, counters, sequencer
// depends on gic_pkg and gic_root_div
//
// One item is a gamepad poll; one result item comes back per poll. A valid
// poll runs a sequencer over one shared 30x16 multiplier and one shared
// 16-step root/divide unit: per stick a square root and two divides, per
// trigger one divide. That makes up to eight passes of the root/divide unit,
// and they set the time. A stick whose squared length is within its deadzone
// squared skips its passes, one whose clamped root is within the deadzone
// skips its divides, and a trigger at or below its deadzone skips its pass.
// A poll that is invalid or arrives while the pad is disabled repeats the
// last result. The next poll is taken while a finished result still waits
// on the output register; a finished result waits in the sequencer while
// that register is still full.
module gamepad_input_conditioner_core import gic_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_poll_valid,
  input  logic [15:0]        in_button_word,
  input  logic signed [15:0] in_left_stick_x,
  input  logic signed [15:0] in_left_stick_y,
  input  logic signed [15:0] in_right_stick_x,
  input  logic signed [15:0] in_right_stick_y,
  input  logic [7:0]         in_left_trigger_raw,
  input  logic [7:0]         in_right_trigger_raw,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_held_buttons,
  output logic               out_any_press,
  output logic [23:0]        out_idle_polls,
  output logic [23:0]        out_idle_confirm_polls,
  output logic signed [15:0] out_left_out_x,
  output logic signed [15:0] out_left_out_y,
  output logic signed [15:0] out_right_out_x,
  output logic signed [15:0] out_right_out_y,
  output logic [14:0]        out_left_trigger_level,
  output logic [14:0]        out_right_trigger_level,
  output logic [7:0]         out_stick_directions,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [14:0]        cfg_data
);

  typedef enum logic [14:0] {
    ST_IDLE = 15'b000000000000001,
    ST_SQX  = 15'b000000000000010,
    ST_SQY  = 15'b000000000000100,
    ST_DZ   = 15'b000000000001000,
    ST_CMP  = 15'b000000000010000,
    ST_SQRT = 15'b000000000100000,
    ST_NUM  = 15'b000000001000000,
    ST_DEN  = 15'b000000010000000,
    ST_MX   = 15'b000000100000000,
    ST_DIVX = 15'b000001000000000,
    ST_MY   = 15'b000010000000000,
    ST_DIVY = 15'b000100000000000,
    ST_TRIG = 15'b001000000000000,
    ST_TDIV = 15'b010000000000000,
    ST_FIN  = 15'b100000000000000
  } state_t;

  // configuration registers
  logic        pad_disabled_r;
  logic [14:0] stick_dz_r;
  logic [7:0]  trig_dz_r;
  logic [14:0] dir_thr_r;

  // sample state
  logic [15:0]                prev_buttons_r;
  logic [3:0][15:0]           prev_axes_r;
  logic [IDLE_COUNT_BITS-1:0] idle_cnt_r;
  logic [IDLE_COUNT_BITS-1:0] confirm_cnt_r;
  logic [7:0]                 lraw_r;
  logic [7:0]                 rraw_r;

  // held result
  logic [15:0]       res_buttons_r;
  logic              res_press_r;
  logic [7:0]        res_dirs_r;
  logic [3:0][15:0]  res_stick_r;
  logic [1:0][14:0]  res_trig_r;

  // sequencer
  state_t      state_r;
  logic        sel_r;
  logic        phase_r;
  logic        live_r;
  logic [31:0] s_r;
  logic [45:0] p_r;
  logic [15:0] m_r;
  logic [29:0] num_r;
  logic [30:0] den_r;

  // shared multiplier
  logic [29:0] mul_a;
  logic [15:0] mul_b;
  logic [45:0] prod;

  unit_req_t   ureq;
  unit_rsp_t   ursp;
  logic [45:0] u_a;

  logic        in_acc;
  logic        out_free;
  logic [15:0] cur_x;
  logic [15:0] cur_y;
  logic [15:0] ax;
  logic [15:0] ay;
  logic [15:0] c_now;
  logic [15:0] c_held;
  logic [15:0] q_sat;
  logic [15:0] q_signed;
  logic [7:0]  raw_now;
  logic [15:0] fresh;
  logic        coarse_chg;
  logic [7:0]  dirs_now;

  gic_root_div u_root_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (ureq),
    .operand_a (u_a),
    .operand_b (den_r),
    .rsp       (ursp)
  );

  function automatic logic [3:0] dir_bits(input logic [15:0] x, input logic [15:0] y,
                                          input logic [14:0] thr);
    logic signed [16:0] xs;
    logic signed [16:0] ys;
    logic signed [16:0] ts;
    logic [3:0]         d;
    xs = $signed({x[15], x});
    ys = $signed({y[15], y});
    ts = $signed({2'b00, thr});
    d[0] = ys > ts;
    d[1] = ys < -ts;
    d[2] = xs < -ts;
    d[3] = xs > ts;
    return d;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // current stick operands and magnitudes
  always_comb begin
    cur_x   = prev_axes_r[{sel_r, 1'b0}];
    cur_y   = prev_axes_r[{sel_r, 1'b1}];
    ax      = cur_x[15] ? (~cur_x + 16'd1) : cur_x;
    ay      = cur_y[15] ? (~cur_y + 16'd1) : cur_y;
    c_now   = (ursp.result > {1'b0, FULL_SCALE}) ? {1'b0, FULL_SCALE} : ursp.result;
    c_held  = (m_r > {1'b0, FULL_SCALE}) ? {1'b0, FULL_SCALE} : m_r;
    q_sat   = (ursp.result > {1'b0, FULL_SCALE}) ? {1'b0, FULL_SCALE} : ursp.result;
    q_signed = ((state_r == ST_DIVX) ? cur_x[15] : cur_y[15]) ? (~q_sat + 16'd1) : q_sat;
    raw_now = sel_r ? rraw_r : lraw_r;
    fresh   = ~prev_buttons_r & in_button_word;
    coarse_chg = (((in_left_stick_x ^ prev_axes_r[0]) & COARSE_AXIS) != 16'd0)
              || (((in_left_stick_y ^ prev_axes_r[1]) & COARSE_AXIS) != 16'd0)
              || (((in_right_stick_x ^ prev_axes_r[2]) & COARSE_AXIS) != 16'd0)
              || (((in_right_stick_y ^ prev_axes_r[3]) & COARSE_AXIS) != 16'd0);
    dirs_now = {dir_bits(res_stick_r[2], res_stick_r[3], dir_thr_r),
                dir_bits(res_stick_r[0], res_stick_r[1], dir_thr_r)};
  end

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_SQX:  begin mul_a = 30'(ax); mul_b = ax; end
      ST_SQY:  begin mul_a = 30'(ay); mul_b = ay; end
      ST_DZ:   begin mul_a = 30'(stick_dz_r); mul_b = {1'b0, stick_dz_r}; end
      ST_NUM:  begin mul_a = 30'(c_held - {1'b0, stick_dz_r}); mul_b = {1'b0, FULL_SCALE}; end
      ST_DEN:  begin mul_a = 30'(m_r); mul_b = {1'b0, FULL_SCALE - stick_dz_r}; end
      ST_MX:   begin mul_a = num_r; mul_b = ax; end
      ST_MY:   begin mul_a = num_r; mul_b = ay; end
      ST_TRIG: begin mul_a = 30'(raw_now - trig_dz_r); mul_b = {1'b0, FULL_SCALE}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    prod = {16'd0, mul_a} * {30'd0, mul_b};
  end

  // root/divide requests
  always_comb begin
    ureq.start = 1'b0;
    ureq.op    = UOP_DIV;
    u_a        = p_r;
    if (state_r == ST_SQRT) begin
      ureq.start = !phase_r;
      ureq.op    = UOP_SQRT;
      u_a        = 46'(s_r);
    end else if (state_r == ST_DIVX || state_r == ST_DIVY || state_r == ST_TDIV) begin
      ureq.start = !phase_r;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_disabled_r <= 1'b0;
      stick_dz_r     <= STICK_DZ_RST;
      trig_dz_r      <= TRIG_DZ_RST;
      dir_thr_r      <= DIR_THR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_PAD_DISABLED: pad_disabled_r <= cfg_data[0];
        CFG_STICK_DZ:     stick_dz_r     <= cfg_data;
        CFG_TRIG_DZ:      trig_dz_r      <= cfg_data[7:0];
        CFG_DIR_THR:      dir_thr_r      <= cfg_data;
        default:          pad_disabled_r <= pad_disabled_r;
      endcase
    end
  end

  // sequencer and held state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      sel_r          <= 1'b0;
      phase_r        <= 1'b0;
      live_r         <= 1'b0;
      out_valid      <= 1'b0;
      prev_buttons_r <= '0;
      prev_axes_r    <= '0;
      idle_cnt_r     <= '0;
      confirm_cnt_r  <= '0;
      res_buttons_r  <= '0;
      res_press_r    <= 1'b0;
      res_dirs_r     <= '0;
      res_stick_r    <= '0;
      res_trig_r     <= '0;
    end else begin
      // result valid: set when a finished item is published, cleared when taken
      if (state_r == ST_FIN && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (pad_disabled_r || !in_poll_valid) begin
              live_r  <= 1'b0;
              state_r <= ST_FIN;
            end else begin
              live_r <= 1'b1;
              idle_cnt_r <= (fresh != 16'd0) ? '0 :
                            ((idle_cnt_r == IDLE_MAX) ? idle_cnt_r
                                                      : idle_cnt_r + IDLE_COUNT_BITS'(1));
              confirm_cnt_r <= ((fresh & (MASK_A | MASK_START)) != 16'd0) ? '0 :
                               ((confirm_cnt_r == IDLE_MAX) ? confirm_cnt_r
                                : confirm_cnt_r + IDLE_COUNT_BITS'(1));
              res_press_r    <= (fresh != 16'd0) || coarse_chg;
              res_buttons_r  <= in_button_word;
              prev_buttons_r <= in_button_word;
              prev_axes_r    <= {in_right_stick_y, in_right_stick_x,
                                 in_left_stick_y, in_left_stick_x};
              lraw_r  <= in_left_trigger_raw;
              rraw_r  <= in_right_trigger_raw;
              sel_r   <= 1'b0;
              state_r <= ST_SQX;
            end
          end
        end
        ST_SQX: begin
          p_r     <= prod;
          state_r <= ST_SQY;
        end
        ST_SQY: begin
          s_r     <= p_r[31:0];
          p_r     <= prod;
          state_r <= ST_DZ;
        end
        ST_DZ: begin
          s_r     <= s_r + p_r[31:0];
          p_r     <= prod;
          state_r <= ST_CMP;
        end
        ST_CMP: begin
          if (s_r <= p_r[31:0]) begin
            res_stick_r[{sel_r, 1'b0}] <= '0;
            res_stick_r[{sel_r, 1'b1}] <= '0;
            sel_r   <= !sel_r;
            state_r <= sel_r ? ST_TRIG : ST_SQX;
          end else begin
            phase_r <= 1'b0;
            state_r <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (!phase_r) begin
            phase_r <= 1'b1;
          end else if (ursp.done) begin
            phase_r <= 1'b0;
            m_r     <= ursp.result;
            // inside the deadzone after clamping to full scale
            if (c_now <= {1'b0, stick_dz_r}) begin
              res_stick_r[{sel_r, 1'b0}] <= '0;
              res_stick_r[{sel_r, 1'b1}] <= '0;
              sel_r   <= !sel_r;
              state_r <= sel_r ? ST_TRIG : ST_SQX;
            end else begin
              state_r <= ST_NUM;
            end
          end
        end
        ST_NUM: begin
          p_r     <= prod;
          state_r <= ST_DEN;
        end
        ST_DEN: begin
          num_r   <= p_r[29:0];
          p_r     <= prod;
          state_r <= ST_MX;
        end
        ST_MX: begin
          den_r   <= p_r[30:0];
          p_r     <= prod;
          state_r <= ST_DIVX;
        end
        ST_DIVX: begin
          if (!phase_r) begin
            phase_r <= 1'b1;
          end else if (ursp.done) begin
            phase_r <= 1'b0;
            res_stick_r[{sel_r, 1'b0}] <= q_signed;
            state_r <= ST_MY;
          end
        end
        ST_MY: begin
          p_r     <= prod;
          state_r <= ST_DIVY;
        end
        ST_DIVY: begin
          if (!phase_r) begin
            phase_r <= 1'b1;
          end else if (ursp.done) begin
            phase_r <= 1'b0;
            res_stick_r[{sel_r, 1'b1}] <= q_signed;
            sel_r   <= !sel_r;
            state_r <= sel_r ? ST_TRIG : ST_SQX;
          end
        end
        ST_TRIG: begin
          if (raw_now <= trig_dz_r || trig_dz_r == TRIG_FULL) begin
            res_trig_r[sel_r] <= '0;
            sel_r   <= !sel_r;
            state_r <= sel_r ? ST_FIN : ST_TRIG;
          end else begin
            p_r     <= prod;
            den_r   <= 31'(TRIG_FULL - trig_dz_r);
            phase_r <= 1'b0;
            state_r <= ST_TDIV;
          end
        end
        ST_TDIV: begin
          if (!phase_r) begin
            phase_r <= 1'b1;
          end else if (ursp.done) begin
            phase_r <= 1'b0;
            res_trig_r[sel_r] <= q_sat[14:0];
            sel_r   <= !sel_r;
            state_r <= sel_r ? ST_FIN : ST_TRIG;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            if (live_r) res_dirs_r <= dirs_now;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // output register, loaded when the finished item is published
  always_ff @(posedge clk) begin
    if (state_r == ST_FIN && out_free) begin
      out_held_buttons        <= res_buttons_r;
      out_any_press           <= res_press_r;
      out_idle_polls          <= 24'(idle_cnt_r);
      out_idle_confirm_polls  <= 24'(confirm_cnt_r);
      out_left_out_x          <= res_stick_r[0];
      out_left_out_y          <= res_stick_r[1];
      out_right_out_x         <= res_stick_r[2];
      out_right_out_y         <= res_stick_r[3];
      out_left_trigger_level  <= res_trig_r[0];
      out_right_trigger_level <= res_trig_r[1];
      out_stick_directions    <= live_r ? dirs_now : res_dirs_r;
    end
  end

endmodule

// ===== design/gic_core_checker.sv =====
// port-level checker for the gamepad input conditioner, bound to the top level
// depends on gic_pkg and the assertion macro header
`include "gamepad_input_conditioner_core_macros.svh"

module gic_core_checker import gic_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_left_out_x,
  input logic signed [15:0] out_left_out_y,
  input logic signed [15:0] out_right_out_x,
  input logic signed [15:0] out_right_out_y
);

  // a stalled result stays offered
  `GIC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

  // no result right after reset
  `GIC_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !out_valid, "result valid after reset")

  // one item at a time: busy after an accepted item
  `GIC_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "ready right after accept")

  // conditioned sticks never reach the negative full-scale code
  `GIC_ASSERT(a_stick_range, out_valid |-> (out_left_out_x != 16'sh8000)
    && (out_left_out_y != 16'sh8000) && (out_right_out_x != 16'sh8000)
    && (out_right_out_y != 16'sh8000), "stick output out of range")

endmodule

bind gamepad_input_conditioner_core gic_core_checker u_gic_core_checker (.*);

// ===== test/gamepad_input_conditioner_core_test.sv =====
// self-checking testbench for gamepad_input_conditioner_core
// depends on gic_pkg and the core RTL; compares every result item with its own predictor
module gamepad_input_conditioner_core_test;
  import gic_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic               pv;
    logic [15:0]        buttons;
    logic signed [15:0] lx, ly, rx, ry;
    logic [7:0]         lt, rt;
  } poll_t;

  typedef struct {
    logic [15:0]        held;
    logic               press;
    logic [23:0]        idle, idle_confirm;
    logic signed [15:0] lx, ly, rx, ry;
    logic [14:0]        lt, rt;
    logic [7:0]         dirs;
  } pad_state_t;

  typedef struct {
    cfg_index_t  idx;
    logic [14:0] data;
  } reg_write_t;

  logic clk, rst_n;
  logic in_valid, in_ready, in_poll_valid;
  logic [15:0] in_button_word;
  logic signed [15:0] in_left_stick_x, in_left_stick_y, in_right_stick_x, in_right_stick_y;
  logic [7:0] in_left_trigger_raw, in_right_trigger_raw;
  logic out_valid, out_ready;
  logic [15:0] out_held_buttons;
  logic out_any_press;
  logic [23:0] out_idle_polls, out_idle_confirm_polls;
  logic signed [15:0] out_left_out_x, out_left_out_y, out_right_out_x, out_right_out_y;
  logic [14:0] out_left_trigger_level, out_right_trigger_level;
  logic [7:0] out_stick_directions;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [14:0] cfg_data;

  gamepad_input_conditioner_core DUT (.*);

  // pending stimulus and expected results
  poll_t      poll_q[$];
  reg_write_t reg_q[$];
  pad_state_t expected_q[$];
  bit         failed = 0;
  bit         no_idle = 0;

  // shadow of registers and block state
  logic        sh_disabled;
  logic [14:0] sh_stick_dz, sh_dir_thr;
  logic [7:0]  sh_trig_dz;
  logic [15:0] prev_buttons;
  logic [15:0] prev_axes[4];
  pad_state_t  last_out;

  // clock
  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, t;
    root = 0;
    for (int k = 16; k >= 0; k--) begin
      t = root | (64'd1 << k);
      if (t * t <= n) root = t;
    end
    return root;
  endfunction

  // radial deadzone and rescale of one stick
  task automatic shape_stick(input logic signed [15:0] x, y,
                             output logic signed [15:0] ox, oy);
    longint unsigned ax, ay, s, dz, m, c, num, den, qx, qy;
    ax = (x < 0) ? 64'(-longint'(x)) : 64'(x);
    ay = (y < 0) ? 64'(-longint'(y)) : 64'(y);
    s = ax * ax + ay * ay;
    dz = sh_stick_dz;
    ox = 0;
    oy = 0;
    if (s > dz * dz) begin
      m = int_sqrt(s);
      c = (m < 32767) ? m : 32767;
      if (c > dz && m != 0) begin
        num = (c - dz) * 32767;
        den = m * (32767 - dz);
        qx = ax * num / den;
        qy = ay * num / den;
        if (qx > 32767) qx = 32767;
        if (qy > 32767) qy = 32767;
        ox = (x < 0) ? -16'(qx) : 16'(qx);
        oy = (y < 0) ? -16'(qy) : 16'(qy);
      end
    end
  endtask

  function automatic logic [14:0] trigger_level(logic [7:0] raw);
    int unsigned tdz;
    tdz = sh_trig_dz;
    if (raw <= tdz || tdz >= 255) return 0;
    return 15'((int'(raw) - tdz) * 32767 / (255 - tdz));
  endfunction

  function automatic logic [3:0] dir_bits(logic signed [15:0] x, y);
    int t;
    logic [3:0] d;
    t = sh_dir_thr;
    d = 0;
    if (int'(y) > t) d[0] = 1;
    if (int'(y) < -t) d[1] = 1;
    if (int'(x) < -t) d[2] = 1;
    if (int'(x) > t) d[3] = 1;
    return d;
  endfunction

  function automatic logic [23:0] bump(logic [23:0] v);
    return (v == 24'hFFFFFF) ? v : v + 1;
  endfunction

  // next result of the block for one accepted poll
  task automatic condition_poll(input poll_t p, output pad_state_t r);
    logic [15:0] fresh, axes[4];
    logic press;
    if (!sh_disabled && p.pv) begin
      axes[0] = p.lx; axes[1] = p.ly; axes[2] = p.rx; axes[3] = p.ry;
      fresh = ~prev_buttons & p.buttons;
      last_out.idle = (fresh != 0) ? 24'd0 : bump(last_out.idle);
      last_out.idle_confirm = ((fresh & (MASK_A | MASK_START)) != 0) ? 24'd0
                              : bump(last_out.idle_confirm);
      press = (fresh != 0);
      for (int i = 0; i < 4; i++) begin
        if (((axes[i] ^ prev_axes[i]) & COARSE_AXIS) != 0) press = 1;
        prev_axes[i] = axes[i];
      end
      prev_buttons = p.buttons;
      last_out.held = p.buttons;
      last_out.press = press;
      shape_stick(p.lx, p.ly, last_out.lx, last_out.ly);
      shape_stick(p.rx, p.ry, last_out.rx, last_out.ry);
      last_out.dirs = {dir_bits(last_out.rx, last_out.ry), dir_bits(last_out.lx, last_out.ly)};
      last_out.lt = trigger_level(p.lt);
      last_out.rt = trigger_level(p.rt);
    end
    r = last_out;
  endtask

  task automatic check_field(string name, longint exp, longint act);
    if (exp != act) begin
      $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, exp, act);
      failed = 1;
    end
  endtask

  // input driver
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 0;
      end else if (poll_q.size() > 0) begin
        poll_t p;
        p = poll_q.pop_front();
        in_poll_valid <= p.pv;
        in_button_word <= p.buttons;
        in_left_stick_x <= p.lx;
        in_left_stick_y <= p.ly;
        in_right_stick_x <= p.rx;
        in_right_stick_y <= p.ry;
        in_left_trigger_raw <= p.lt;
        in_right_trigger_raw <= p.rt;
        in_valid <= 1;
        in_gap <= pick_gap();
      end else begin
        in_valid <= 0;
      end
    end
  end

  // register write driver
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_valid <= 0;
    end else if (!cfg_valid || cfg_ready) begin
      if (reg_q.size() > 0) begin
        reg_write_t w;
        w = reg_q.pop_front();
        cfg_index <= w.idx;
        cfg_data <= w.data;
        cfg_valid <= 1;
      end else begin
        cfg_valid <= 0;
      end
    end
  end

  // receiver with random stalls and one long hold-off
  int out_gap = 0, results_seen = 0;
  bit long_hold_done = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) results_seen <= results_seen + 1;
      if (!long_hold_done && results_seen == 600) begin
        long_hold_done <= 1;
        out_gap <= 700;
        out_ready <= 0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 0;
      end else if (out_ready && !no_idle && $urandom_range(0, 3) == 0) begin
        out_gap <= pick_gap();
        out_ready <= 0;
      end else begin
        out_ready <= 1;
      end
    end
  end

  // monitor: register shadow, prediction and comparison
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result item with no expectation, held_buttons %0h", $time,
                   out_held_buttons);
          failed = 1;
        end else begin
          pad_state_t e;
          e = expected_q.pop_front();
          check_field("held_buttons", e.held, out_held_buttons);
          check_field("any_press", e.press, out_any_press);
          check_field("idle_polls", e.idle, out_idle_polls);
          check_field("idle_confirm_polls", e.idle_confirm, out_idle_confirm_polls);
          check_field("left_out_x", e.lx, out_left_out_x);
          check_field("left_out_y", e.ly, out_left_out_y);
          check_field("right_out_x", e.rx, out_right_out_x);
          check_field("right_out_y", e.ry, out_right_out_y);
          check_field("left_trigger_level", e.lt, out_left_trigger_level);
          check_field("right_trigger_level", e.rt, out_right_trigger_level);
          check_field("stick_directions", e.dirs, out_stick_directions);
        end
      end
      if (in_valid && in_ready) begin
        poll_t p;
        pad_state_t r;
        p.pv = in_poll_valid; p.buttons = in_button_word;
        p.lx = in_left_stick_x; p.ly = in_left_stick_y;
        p.rx = in_right_stick_x; p.ry = in_right_stick_y;
        p.lt = in_left_trigger_raw; p.rt = in_right_trigger_raw;
        condition_poll(p, r);
        expected_q.push_back(r);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index_t'(cfg_index))
          CFG_PAD_DISABLED: sh_disabled = cfg_data[0];
          CFG_STICK_DZ:     sh_stick_dz = cfg_data;
          CFG_TRIG_DZ:      sh_trig_dz = cfg_data[7:0];
          CFG_DIR_THR:      sh_dir_thr = cfg_data;
          default: ;
        endcase
      end
      // watchdog
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic poll_t make_poll(logic pv, logic [15:0] b, int lx, int ly, int rx, int ry,
                                      int lt, int rt);
    poll_t p;
    p.pv = pv; p.buttons = b;
    p.lx = 16'(lx); p.ly = 16'(ly); p.rx = 16'(rx); p.ry = 16'(ry);
    p.lt = 8'(lt); p.rt = 8'(rt);
    return p;
  endfunction

  function automatic logic [15:0] rand_axis();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) begin
      case ($urandom_range(0, 3))
        0: return 16'h8000;
        1: return 16'h8001;
        2: return 16'h0000;
        default: return 16'h7FFF;
      endcase
    end
    if (r < 5) return 16'($urandom_range(0, 16000)) - 16'd8000;
    return 16'($urandom);
  endfunction

  // wait for the block to drain, including pending register writes
  task automatic drain();
    while (poll_q.size() > 0 || in_valid || expected_q.size() > 0 || reg_q.size() > 0
           || cfg_valid)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_regs(logic dis, logic [14:0] sdz, logic [7:0] tdz, logic [14:0] thr);
    reg_write_t w;
    w.idx = CFG_PAD_DISABLED; w.data = 15'(dis); reg_q.push_back(w);
    w.idx = CFG_STICK_DZ;     w.data = sdz;       reg_q.push_back(w);
    w.idx = CFG_TRIG_DZ;      w.data = 15'(tdz);  reg_q.push_back(w);
    w.idx = CFG_DIR_THR;      w.data = thr;       reg_q.push_back(w);
    drain();
  endtask

  logic [15:0] gen_buttons = 0;

  task automatic random_polls(int n);
    poll_t p;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) gen_buttons = 16'($urandom);
      else gen_buttons ^= 16'($urandom & $urandom & $urandom);
      p.pv = ($urandom_range(0, 9) != 0);
      p.buttons = gen_buttons;
      p.lx = rand_axis(); p.ly = rand_axis(); p.rx = rand_axis(); p.ry = rand_axis();
      p.lt = ($urandom_range(0, 4) == 0) ? 8'(sh_trig_dz + $urandom_range(0, 1))
                                         : 8'($urandom);
      p.rt = 8'($urandom);
      poll_q.push_back(p);
    end
    drain();
  endtask

  // stimulus
  initial begin
    rst_n = 0;
    in_valid = 0; in_poll_valid = 0; in_button_word = 0;
    in_left_stick_x = 0; in_left_stick_y = 0; in_right_stick_x = 0; in_right_stick_y = 0;
    in_left_trigger_raw = 0; in_right_trigger_raw = 0;
    out_ready = 0; cfg_valid = 0; cfg_index = 0; cfg_data = 0;
    sh_disabled = 0; sh_stick_dz = STICK_DZ_RST; sh_trig_dz = TRIG_DZ_RST;
    sh_dir_thr = DIR_THR_RST;
    prev_buttons = 0;
    for (int i = 0; i < 4; i++) prev_axes[i] = 0;
    last_out = '{default: 0};
    repeat (10) @(posedge clk);
    rst_n <= 1;

    // directed polls at reset settings
    poll_q.push_back(make_poll(0, 16'hFFFF, 32767, 32767, -32768, -32768, 255, 255));
    poll_q.push_back(make_poll(1, 16'h0000, 0, 0, 0, 0, 0, 0));
    poll_q.push_back(make_poll(1, 16'hFFFF, 32767, 32767, -32768, -32768, 255, 255));
    poll_q.push_back(make_poll(1, 16'h0000, -32768, 32767, 32767, -32768, 30, 31));
    poll_q.push_back(make_poll(1, 16'h1000, 7864, 0, 0, -7864, 29, 254));
    poll_q.push_back(make_poll(1, 16'h0010, 7865, 0, 0, -7865, 31, 30));
    poll_q.push_back(make_poll(1, 16'h0011, 5600, 5600, -5600, 5600, 128, 0));
    poll_q.push_back(make_poll(1, 16'h0001, 16384, 0, 0, 16384, 200, 100));
    poll_q.push_back(make_poll(0, 16'h5555, -1, -1, -1, -1, 1, 1));
    poll_q.push_back(make_poll(1, 16'h0001, -16384, 0, 0, -16384, 200, 100));
    poll_q.push_back(make_poll(1, 16'h000F, 20000, -20000, -32767, 32767, 255, 0));
    poll_q.push_back(make_poll(1, 16'hAAAA, 10000, -9000, 9000, -10000, 60, 240));
    poll_q.push_back(make_poll(1, 16'h5555, 32767, 0, 0, 32767, 255, 255));
    poll_q.push_back(make_poll(1, 16'h5555, 32767, 0, 0, 32767, 255, 255));
    drain();

    // disabled pad ignores polls
    set_regs(1, STICK_DZ_RST, TRIG_DZ_RST, DIR_THR_RST);
    poll_q.push_back(make_poll(1, 16'hFFFF, 1000, 30000, -30000, 5, 100, 200));
    random_polls(30);

    // zero deadzones and threshold, no idling for a while
    no_idle = 1;
    set_regs(0, 15'd0, 8'd0, 15'd0);
    poll_q.push_back(make_poll(1, 16'h1010, 1, 0, 0, -1, 0, 1));
    random_polls(150);
    no_idle = 0;
    random_polls(150);

    // maximum deadzones and threshold
    set_regs(0, 15'd32766, 8'd254, 15'd32767);
    poll_q.push_back(make_poll(1, 16'h0000, -32768, -32768, 32767, 32767, 254, 255));
    random_polls(150);

    // reset values, with the long receiver hold-off landing here
    set_regs(0, STICK_DZ_RST, TRIG_DZ_RST, DIR_THR_RST);
    random_polls(400);

    // random settings
    for (int k = 0; k < 5; k++) begin
      set_regs(0, 15'($urandom_range(0, 32766)), 8'($urandom_range(0, 254)),
               15'($urandom_range(0, 32767)));
      random_polls(100);
    end

    drain();
    repeat (200) @(posedge clk);
    if (!failed && expected_q.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
